>>> sv/nffa_pkg.sv
`timescale 1ns / 1ps
package nffa_pkg;

  localparam int REQ_BYTES_W = 16;
  localparam int BLK_ADDR_W  = 12;
  localparam int MIN_GROW_W  = 13;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic ST_DONE = 1'b0;
  localparam logic ST_OOM  = 1'b1;

  localparam logic [MIN_GROW_W-1:0] MIN_GROW_RESET = 13'd1024;

  localparam logic REG_MIN_GROW = 1'b0;

endpackage

>>> sv/next_fit_free_list_allocator.sv
`timescale 1ns / 1ps
// Next-fit free-list heap allocator. Each transfer on the input carries one
// allocate or release request and yields exactly one result transfer. The
// free list lives in a single-port header memory with a registered read, so
// the walks read one header at a time. An allocate walks the headers from the
// rover and splits a larger block when it finds one; a release walks from the
// rover to its insertion point, and one with a bad address skips the walk.
// Growing the heap inside an allocate writes the new block and then runs the
// release walk on it, and an allocate that cannot grow reports out of memory.
// One request is in flight at a time; the next request is taken while the
// previous result still waits in the output register, and a result stalled
// there holds the block in its final state until the register frees up.
module next_fit_free_list_allocator import nffa_pkg::*; #(
  parameter int HEAP_UNITS = 4096,
  parameter int UNIT_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] request_bytes, [27:16] block_address
  input  logic [0:0]  in_tuser,   // [0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [11:0] payload_address, [12] status
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int IW  = $clog2(HEAP_UNITS);
  localparam int SW  = IW + 1;
  localparam int HW  = IW + SW;
  localparam int BW  = $clog2(HEAP_UNITS + 1);
  localparam int XW  = REQ_BYTES_W + 1;
  localparam int NW  = XW;
  localparam int CW  = ((NW > SW) ? NW : SW) + 2;
  localparam int EW  = ((IW > BLK_ADDR_W) ? IW : BLK_ADDR_W) + 2;
  localparam int RSH = 24;
  localparam int RW  = 25;
  localparam int QW  = NW + 7;
  localparam int ALIMIT = 3 * HEAP_UNITS + 8;
  localparam int RLIMIT = HEAP_UNITS + 2;
  localparam int ASW = $clog2(ALIMIT + 1);
  localparam int RSW = $clog2(RLIMIT + 1);
  localparam logic [RW-1:0] RECIP = RW'((1 << RSH) / UNIT_BYTES);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_APREV, S_AWALK, S_CARVE, S_CARVE2, S_GROW, S_REROV,
    S_RSTART, S_RWALK, S_RBP, S_RQ, S_RWP, S_OUT
  } state_t;

  logic [HW-1:0] mem [HEAP_UNITS];
  logic [HW-1:0] mem_q;

  state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [11:0]     out_addr_r, out_addr_nxt;
  logic            out_status_r, out_status_nxt;
  logic [11:0]     res_addr_r, res_addr_nxt;
  logic            res_status_r, res_status_nxt;
  logic [MIN_GROW_W-1:0] min_grow_r, min_grow_nxt;
  logic [IW-1:0]   sent_r, sent_nxt;
  logic [IW-1:0]   rover_r, rover_nxt;
  logic [BW-1:0]   brk_r, brk_nxt;
  logic [XW-1:0]   x_r, x_nxt;
  logic [XW+RW-1:0] prod_r, prod_nxt;
  logic [NW-1:0]   n_r, n_nxt;
  logic [IW-1:0]   p_r, p_nxt;
  logic [IW-1:0]   prev_r, prev_nxt;
  logic [SW-1:0]   prev_size_r, prev_size_nxt;
  logic [IW-1:0]   bp_r, bp_nxt;
  logic [IW-1:0]   np_r, np_nxt;
  logic [SW-1:0]   sp_r, sp_nxt;
  logic [SW-1:0]   sbp_r, sbp_nxt;
  logic [IW-1:0]   bnext_r, bnext_nxt;
  logic [ASW-1:0]  asteps_r, asteps_nxt;
  logic [RSW-1:0]  rsteps_r, rsteps_nxt;
  logic            in_grow_r, in_grow_nxt;
  logic            rd_zero_r;

  logic            rd_en;
  logic [IW-1:0]   rd_addr;
  logic            wr_en;
  logic            wr_full;
  logic [IW-1:0]   wr_addr;
  logic [IW-1:0]   wr_next;
  logic [SW-1:0]   wr_size;

  logic [IW-1:0]   hdr_next;
  logic [SW-1:0]   hdr_size;
  logic            in_xfer;
  logic [XW-1:0]   x_in;
  logic [EW-1:0]   rel_bp;
  logic [NW-1:0]   q0;
  logic [QW-1:0]   qu;
  logic [QW-1:0]   rem;
  logic [CW-1:0]   s_c;
  logic [CW-1:0]   n_c;
  logic [CW-1:0]   nu;
  logic [SW-1:0]   s_less;
  logic            found;
  logic [SW-1:0]   nb_size;
  logic [IW-1:0]   nb_next;

  assign hdr_next = rd_zero_r ? sent_r : mem_q[HW-1:SW];
  assign hdr_size = rd_zero_r ? '0 : mem_q[SW-1:0];

  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_status_r, out_addr_r};
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_MIN_GROW) ? {19'd0, min_grow_r} : 32'd0;

  assign x_in   = XW'(in_tdata[15:0]) + XW'(UNIT_BYTES - 1);
  assign rel_bp = EW'(in_tdata[27:16]) - EW'(1);

  assign q0   = prod_r[RSH +: NW];
  assign qu   = QW'(q0) * QW'(UNIT_BYTES);
  assign rem  = QW'(x_r) - qu;
  assign s_c  = CW'(hdr_size);
  assign n_c  = CW'(n_r);
  assign nu   = (n_c > CW'(min_grow_r)) ? n_c : CW'(min_grow_r);
  assign s_less = SW'(s_c - n_c);

  assign found = ((bp_r > p_r) && (bp_r < hdr_next)) ||
                 ((p_r >= hdr_next) && ((bp_r > p_r) || (bp_r < hdr_next)));

  always_comb begin
    if ((CW'(bp_r) + CW'(sbp_r)) == CW'(np_r)) begin
      nb_size = SW'(sbp_r + hdr_size);
      nb_next = hdr_next;
    end else begin
      nb_size = sbp_r;
      nb_next = np_r;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    min_grow_nxt   = min_grow_r;
    sent_nxt       = sent_r;
    rover_nxt      = rover_r;
    brk_nxt        = brk_r;
    x_nxt          = x_r;
    prod_nxt       = prod_r;
    n_nxt          = n_r;
    p_nxt          = p_r;
    prev_nxt       = prev_r;
    prev_size_nxt  = prev_size_r;
    bp_nxt         = bp_r;
    np_nxt         = np_r;
    sp_nxt         = sp_r;
    sbp_nxt        = sbp_r;
    bnext_nxt      = bnext_r;
    asteps_nxt     = asteps_r;
    rsteps_nxt     = rsteps_r;
    in_grow_nxt    = in_grow_r;
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_full = 1'b0;
    wr_addr = '0;
    wr_next = '0;
    wr_size = '0;

    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
        cfg_paddr[2] == REG_MIN_GROW) begin
      min_grow_nxt = cfg_pwdata[MIN_GROW_W-1:0];
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_tuser[0] == OP_ALLOC) begin
            x_nxt     = x_in;
            prod_nxt  = (XW+RW)'(x_in) * (XW+RW)'(RECIP);
            state_nxt = S_DIV;
          end else if (in_tdata[27:16] < BLK_ADDR_W'(2) ||
                       rel_bp >= EW'(brk_r) || rel_bp >= EW'(HEAP_UNITS)) begin
            res_addr_nxt   = '0;
            res_status_nxt = ST_DONE;
            state_nxt      = S_OUT;
          end else begin
            bp_nxt      = IW'(rel_bp);
            in_grow_nxt = 1'b0;
            state_nxt   = S_RSTART;
          end
        end
      end
      S_DIV: begin
        n_nxt      = q0 + NW'(1) + NW'(rem >= QW'(UNIT_BYTES));
        asteps_nxt = '0;
        rd_en      = 1'b1;
        rd_addr    = rover_r;
        state_nxt  = S_APREV;
      end
      S_APREV: begin
        prev_nxt      = rover_r;
        prev_size_nxt = hdr_size;
        p_nxt         = hdr_next;
        rd_en         = 1'b1;
        rd_addr       = hdr_next;
        state_nxt     = S_AWALK;
      end
      S_AWALK: begin
        asteps_nxt = asteps_r + ASW'(1);
        if (asteps_r >= ASW'(ALIMIT)) begin
          res_addr_nxt   = '0;
          res_status_nxt = ST_OOM;
          state_nxt      = S_OUT;
        end else if (s_c == n_c) begin
          wr_en     = 1'b1;
          wr_full   = 1'b1;
          wr_addr   = prev_r;
          wr_next   = hdr_next;
          wr_size   = prev_size_r;
          rover_nxt = prev_r;
          res_addr_nxt   = 12'(CW'(p_r) + CW'(1));
          res_status_nxt = ST_DONE;
          state_nxt      = S_OUT;
        end else if (s_c > n_c) begin
          wr_en     = 1'b1;
          wr_addr   = p_r;
          wr_next   = hdr_next;
          wr_size   = s_less;
          p_nxt     = IW'(CW'(p_r) + CW'(s_less));
          state_nxt = S_CARVE;
        end else if (p_r == rover_r) begin
          state_nxt = S_GROW;
        end else begin
          prev_nxt      = p_r;
          prev_size_nxt = hdr_size;
          p_nxt         = hdr_next;
          rd_en         = 1'b1;
          rd_addr       = hdr_next;
        end
      end
      S_CARVE: begin
        rd_en     = 1'b1;
        rd_addr   = p_r;
        state_nxt = S_CARVE2;
      end
      S_CARVE2: begin
        wr_en     = 1'b1;
        wr_addr   = p_r;
        wr_next   = hdr_next;
        wr_size   = SW'(n_r);
        rover_nxt = prev_r;
        res_addr_nxt   = 12'(CW'(p_r) + CW'(1));
        res_status_nxt = ST_DONE;
        state_nxt      = S_OUT;
      end
      S_GROW: begin
        if ((CW'(brk_r) + nu) > CW'(HEAP_UNITS)) begin
          res_addr_nxt   = '0;
          res_status_nxt = ST_OOM;
          state_nxt      = S_OUT;
        end else begin
          wr_en       = 1'b1;
          wr_addr     = IW'(brk_r);
          wr_size     = SW'(nu);
          brk_nxt     = BW'(CW'(brk_r) + nu);
          bp_nxt      = IW'(brk_r);
          in_grow_nxt = 1'b1;
          state_nxt   = S_RSTART;
        end
      end
      S_REROV: begin
        rd_en     = 1'b1;
        rd_addr   = rover_r;
        state_nxt = S_APREV;
      end
      S_RSTART: begin
        p_nxt      = rover_r;
        rsteps_nxt = '0;
        rd_en      = 1'b1;
        rd_addr    = rover_r;
        state_nxt  = S_RWALK;
      end
      S_RWALK: begin
        if (found) begin
          np_nxt    = hdr_next;
          sp_nxt    = hdr_size;
          rd_en     = 1'b1;
          rd_addr   = bp_r;
          state_nxt = S_RBP;
        end else if (rsteps_r >= RSW'(RLIMIT)) begin
          if (in_grow_r) begin
            state_nxt = S_REROV;
          end else begin
            res_addr_nxt   = '0;
            res_status_nxt = ST_DONE;
            state_nxt      = S_OUT;
          end
        end else begin
          p_nxt      = hdr_next;
          rsteps_nxt = rsteps_r + RSW'(1);
          rd_en      = 1'b1;
          rd_addr    = hdr_next;
        end
      end
      S_RBP: begin
        sbp_nxt   = hdr_size;
        rd_en     = 1'b1;
        rd_addr   = np_r;
        state_nxt = S_RQ;
      end
      S_RQ: begin
        wr_en     = 1'b1;
        wr_full   = 1'b1;
        wr_addr   = bp_r;
        wr_next   = nb_next;
        wr_size   = nb_size;
        sbp_nxt   = nb_size;
        bnext_nxt = nb_next;
        state_nxt = S_RWP;
      end
      S_RWP: begin
        wr_en   = 1'b1;
        wr_full = 1'b1;
        wr_addr = p_r;
        if ((CW'(p_r) + CW'(sp_r)) == CW'(bp_r)) begin
          wr_next = bnext_r;
          wr_size = SW'(sp_r + sbp_r);
        end else begin
          wr_next = bp_r;
          wr_size = sp_r;
        end
        rover_nxt = p_r;
        if (in_grow_r) begin
          state_nxt = S_REROV;
        end else begin
          res_addr_nxt   = '0;
          res_status_nxt = ST_DONE;
          state_nxt      = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = res_addr_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (wr_en && wr_full && wr_addr == '0) begin
      sent_nxt = wr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_addr != '0) begin
      mem[wr_addr] <= {wr_next, wr_size};
    end
    if (rd_en) begin
      mem_q     <= mem[rd_addr];
      rd_zero_r <= (rd_addr == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      min_grow_r  <= MIN_GROW_RESET;
      sent_r      <= '0;
      rover_r     <= '0;
      brk_r       <= BW'(1);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      min_grow_r  <= min_grow_nxt;
      sent_r      <= sent_nxt;
      rover_r     <= rover_nxt;
      brk_r       <= brk_nxt;
    end
    out_addr_r    <= out_addr_nxt;
    out_status_r  <= out_status_nxt;
    res_addr_r    <= res_addr_nxt;
    res_status_r  <= res_status_nxt;
    x_r           <= x_nxt;
    prod_r        <= prod_nxt;
    n_r           <= n_nxt;
    p_r           <= p_nxt;
    prev_r        <= prev_nxt;
    prev_size_r   <= prev_size_nxt;
    bp_r          <= bp_nxt;
    np_r          <= np_nxt;
    sp_r          <= sp_nxt;
    sbp_r         <= sbp_nxt;
    bnext_r       <= bnext_nxt;
    asteps_r      <= asteps_nxt;
    rsteps_r      <= rsteps_nxt;
    in_grow_r     <= in_grow_nxt;
  end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
module tb;
  import nffa_pkg::*;

  localparam int HEAP = 4096;
  localparam int UNIT = 16;

  typedef struct {
    logic [11:0] addr;
    logic        st;
  } result_t;

  typedef struct {
    logic                  op;
    logic [REQ_BYTES_W-1:0] bytes;
    logic [BLK_ADDR_W-1:0]  addr;
    bit                    rel_last;
    bit                    typed;
    logic [11:0]           e_addr;
    logic                  e_st;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  next_fit_free_list_allocator #(.HEAP_UNITS(HEAP), .UNIT_BYTES(UNIT)) DUT (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // heap shadow
  int unsigned hdr_next [HEAP];
  int unsigned hdr_size [HEAP];
  int unsigned free_head, roving, brk, grow_min;

  result_t     pending [$];
  int          live [$];
  int          errors, n_alloc, n_oom, n_release, n_results;

  function automatic int unsigned link_of(int unsigned i);
    i = i % HEAP;
    return (i == 0) ? free_head : hdr_next[i] % HEAP;
  endfunction

  function automatic void set_link(int unsigned i, int unsigned v);
    i = i % HEAP;
    if (i == 0) free_head = v % HEAP;
    else hdr_next[i] = v % HEAP;
  endfunction

  function automatic int unsigned units_of(int unsigned i);
    i = i % HEAP;
    return (i == 0) ? 0 : hdr_size[i];
  endfunction

  function automatic void set_units(int unsigned i, int unsigned v);
    i = i % HEAP;
    if (i != 0) hdr_size[i] = v;
  endfunction

  function automatic void free_block(int unsigned a);
    int unsigned bp, p, q, steps;
    steps = 0;
    if (a < 2) return;
    bp = a - 1;
    if (bp >= brk || bp >= HEAP) return;
    p = roving;
    while (!(bp > p && bp < link_of(p))) begin
      if (p >= link_of(p) && (bp > p || bp < link_of(p))) break;
      p = link_of(p);
      steps++;
      if (steps > HEAP + 2) return;
    end
    q = link_of(p);
    if (bp + units_of(bp) == q) begin
      set_units(bp, units_of(bp) + units_of(q));
      set_link(bp, link_of(q));
    end else begin
      set_link(bp, q);
    end
    if (p + units_of(p) == bp) begin
      set_units(p, units_of(p) + units_of(bp));
      set_link(p, link_of(bp));
    end else begin
      set_link(p, bp);
    end
    roving = p;
  endfunction

  function automatic bit extend_heap(int unsigned units);
    int unsigned nu, up;
    nu = (units < grow_min) ? grow_min : units;
    if (brk + nu > HEAP) return 1'b0;
    up = brk;
    set_units(up, nu);
    brk += nu;
    free_block(up + 1);
    return 1'b1;
  endfunction

  function automatic result_t next_fit_alloc(int unsigned bytes);
    int unsigned n, prv, p, s, steps;
    result_t r;
    n = (bytes + UNIT - 1) / UNIT + 1;
    prv = roving;
    p = link_of(roving);
    steps = 0;
    r.addr = '0;
    r.st = ST_OOM;
    forever begin
      steps++;
      if (steps > 3 * HEAP + 8) break;
      s = units_of(p);
      if (s >= n) begin
        if (s == n) begin
          set_link(prv, link_of(p));
        end else begin
          s -= n;
          set_units(p, s);
          p = (p + s) % HEAP;
          set_units(p, n);
        end
        roving = prv;
        r.addr = 12'((p + 1) % HEAP);
        r.st = ST_DONE;
        return r;
      end
      if (p == roving) begin
        if (!extend_heap(n)) break;
        p = roving;
      end
      prv = p;
      p = link_of(p);
    end
    return r;
  endfunction

  // one request; returns the predicted result
  task automatic send_req(input logic op, input logic [15:0] bytes, input logic [11:0] a,
                          output result_t exp);
    int gap, k;
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = {4'b0, a, bytes};
    do @(posedge clk); while (!in_tready);
    if (op == OP_ALLOC) begin
      exp = next_fit_alloc(bytes);
      if (exp.st == ST_DONE && exp.addr != 0) live.push_back(exp.addr);
      if (exp.st == ST_DONE) n_alloc++;
      else n_oom++;
    end else begin
      free_block(a);
      exp.addr = '0;
      exp.st = ST_DONE;
      n_release++;
    end
    pending.push_back(exp);
    k = $urandom_range(99);
    gap = (k < 65) ? 0 : (k < 95) ? $urandom_range(3, 1) : $urandom_range(40, 10);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain;
    in_tvalid = 1'b0;
    while (pending.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic apb_access(input bit wr, input logic [31:0] d);
    cfg_psel = 1'b1;
    cfg_pwrite = wr;
    cfg_paddr = 3'(REG_MIN_GROW) * 3'd4;
    cfg_pwdata = d;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    if (!wr && cfg_prdata[MIN_GROW_W-1:0] !== d[MIN_GROW_W-1:0]) begin
      $display("%0t: min_grow_units read expected %0d actual %0d", $time, d,
               cfg_prdata);
      errors++;
    end
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
  endtask

  task automatic set_min_grow(input int unsigned v);
    apb_access(1'b1, v);
    grow_min = v;
    apb_access(1'b0, v);
  endtask

  task automatic random_phase(input int count);
    int r, j;
    logic [15:0] b;
    logic [11:0] a;
    result_t e;
    repeat (count) begin
      r = $urandom_range(99);
      if (live.size() > 0 && r < 45) begin
        j = $urandom_range(live.size() - 1);
        a = live[j];
        live.delete(j);
        send_req(OP_RELEASE, 16'($urandom), a, e);
      end else if (r < 48) begin
        case ($urandom_range(2))
          0: a = 12'd0;
          1: a = 12'd1;
          default: a = (brk + 1 <= 4095) ? 12'($urandom_range(4095, brk + 1)) : 12'd1;
        endcase
        send_req(OP_RELEASE, 16'($urandom), a, e);
      end else begin
        j = $urandom_range(99);
        b = (j < 80) ? 16'($urandom_range(255)) :
            (j < 95) ? 16'($urandom_range(4095)) :
            (j < 99) ? 16'($urandom) : 16'hFFFF;
        send_req(OP_ALLOC, b, 12'($urandom), e);
      end
    end
    drain();
  endtask

  // output side: random stalls, with runs of steady readiness
  int stall_left = 0;
  int steady_left = 0;
  always @(negedge clk) begin
    int k;
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else if (steady_left > 0) begin
      out_tready <= 1'b1;
      steady_left--;
    end else begin
      k = $urandom_range(99);
      if (k < 10) steady_left = $urandom_range(60, 20);
      else if (k < 40) stall_left = $urandom_range(2, 0);
      else if (k < 44) stall_left = $urandom_range(40, 8);
      out_tready <= (k < 10) || (k >= 44);
    end
  end

  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result addr %0d status %0d", $time, out_tdata[11:0],
                 out_tdata[12]);
        errors++;
      end else begin
        e = pending.pop_front();
        if (out_tdata[11:0] !== e.addr) begin
          $display("%0t: payload_address expected %0d actual %0d", $time, e.addr,
                   out_tdata[11:0]);
          errors++;
        end
        if (out_tdata[12] !== e.st) begin
          $display("%0t: status expected %0d actual %0d", $time, e.st, out_tdata[12]);
          errors++;
        end
      end
    end
  end

  initial begin
    #2s;
    $display("next_fit_free_list_allocator test failed");
    $finish;
  end

  dir_row_t dir_rows [] = '{
    '{OP_ALLOC,   16'd0,     12'd0,    0, 1, 12'd1025, ST_DONE},
    '{OP_ALLOC,   16'hFFFF,  12'd0,    0, 1, 12'd0,    ST_OOM},
    '{OP_RELEASE, 16'd0,     12'd0,    0, 1, 12'd0,    ST_DONE},
    '{OP_RELEASE, 16'hFFFF,  12'd1,    0, 1, 12'd0,    ST_DONE},
    '{OP_RELEASE, 16'd0,     12'd4095, 0, 1, 12'd0,    ST_DONE},
    '{OP_ALLOC,   16'd1,     12'd0,    0, 0, 12'd0,    ST_DONE},
    '{OP_ALLOC,   16'd16,    12'd0,    0, 0, 12'd0,    ST_DONE},
    '{OP_ALLOC,   16'd17,    12'd0,    0, 0, 12'd0,    ST_DONE},
    '{OP_RELEASE, 16'd0,     12'd0,    1, 0, 12'd0,    ST_DONE},
    '{OP_ALLOC,   16'd15,    12'd0,    0, 0, 12'd0,    ST_DONE},
    '{OP_ALLOC,   16'd32,    12'd0,    0, 0, 12'd0,    ST_DONE},
    '{OP_RELEASE, 16'd0,     12'd0,    1, 0, 12'd0,    ST_DONE},
    '{OP_RELEASE, 16'd0,     12'd0,    1, 0, 12'd0,    ST_DONE},
    '{OP_ALLOC,   16'd16000, 12'd0,    0, 0, 12'd0,    ST_DONE},
    '{OP_ALLOC,   16'd32000, 12'd0,    0, 0, 12'd0,    ST_DONE},
    '{OP_ALLOC,   16'd48000, 12'd0,    0, 0, 12'd0,    ST_DONE},
    '{OP_RELEASE, 16'd0,     12'd0,    1, 0, 12'd0,    ST_DONE},
    '{OP_ALLOC,   16'd100,   12'd0,    0, 0, 12'd0,    ST_DONE}
  };

  initial begin
    result_t e;
    logic [11:0] a;
    errors = 0;
    n_alloc = 0;
    n_oom = 0;
    n_release = 0;
    n_results = 0;
    free_head = 0;
    roving = 0;
    brk = 1;
    grow_min = MIN_GROW_RESET;
    foreach (hdr_next[i]) begin
      hdr_next[i] = 0;
      hdr_size[i] = 0;
    end
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    apb_access(1'b0, MIN_GROW_RESET);

    foreach (dir_rows[i]) begin
      a = dir_rows[i].addr;
      if (dir_rows[i].rel_last && live.size() > 0) a = live.pop_back();
      send_req(dir_rows[i].op, dir_rows[i].bytes, a, e);
      if (dir_rows[i].typed && (e.addr !== dir_rows[i].e_addr || e.st !== dir_rows[i].e_st))
      begin
        $display("%0t: row %0d predicted %0d/%0d, table says %0d/%0d", $time, i, e.addr,
                 e.st, dir_rows[i].e_addr, dir_rows[i].e_st);
        errors++;
      end
    end
    drain();

    set_min_grow(1);
    random_phase(300);
    set_min_grow(8191);
    random_phase(150);
    set_min_grow(0);
    random_phase(250);
    set_min_grow(4096);
    random_phase(150);
    set_min_grow(1024);
    random_phase(250);

    repeat (20) @(posedge clk);
    $display("Covered %0d granted allocations, %0d out-of-memory, %0d releases;",
             n_alloc, n_oom, n_release);
    $display("minimum growth swept over 0, 1, 1024, 4096 and 8191 units, %0d results seen",
             n_results);
    if (errors == 0) begin
      $display("next_fit_free_list_allocator test passed");
    end else begin
      $display("next_fit_free_list_allocator test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/nffa_pkg.sv
sv/next_fit_free_list_allocator.sv
dv/tb.sv
